@@ hdl/assert_macros.svh @@
// assertion macros shared by the speed controller rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the same edge
`define ESP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked at the next edge
`define ESP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/esp_pkg.sv @@
// types, constants and microprogram of the encoder speed pid controller
// no dependencies; used by the sequencer, datapath and top level
package esp_pkg;

    // field widths
    localparam int COUNT_BITS = 16;
    localparam int ENC_W      = 16;
    localparam int REF_W      = 8;
    localparam int GAIN_W     = 16;
    localparam int DUTY_W     = 16;
    localparam int SPEED_W    = 28;

    // internal widths
    localparam int ERR_W      = SPEED_W + 2;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int INTEG_W    = 40;
    localparam int DRIVE_W    = 48;
    localparam int ACC_W      = 64;
    localparam int LO_W       = 24;
    localparam int MA_W       = 33;
    localparam int PROD_W     = MA_W + GAIN_W + 1;
    localparam int DFULL_W    = ACC_W - LO_W;

    // saturation bounds
    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] DRIVE_CAP =
        {{(ACC_W-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KP        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPD_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DTY_SCALE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX   = 3'd6;

    // sequencer operations
    localparam logic [1:0] SEQ_NEXT     = 2'd0;
    localparam logic [1:0] SEQ_WAIT_IN  = 2'd1;
    localparam logic [1:0] SEQ_WAIT_OUT = 2'd2;

    // multiplier operand selects
    localparam logic [2:0] MUL_NONE  = 3'd0;
    localparam logic [2:0] MUL_DELTA = 3'd1;
    localparam logic [2:0] MUL_KP    = 3'd2;
    localparam logic [2:0] MUL_KD    = 3'd3;
    localparam logic [2:0] MUL_KI_LO = 3'd4;
    localparam logic [2:0] MUL_KI_HI = 3'd5;
    localparam logic [2:0] MUL_DS_LO = 3'd6;
    localparam logic [2:0] MUL_DS_HI = 3'd7;

    // accumulator operations
    localparam logic [2:0] ACC_HOLD       = 3'd0;
    localparam logic [2:0] ACC_LOAD       = 3'd1;
    localparam logic [2:0] ACC_ADD        = 3'd2;
    localparam logic [2:0] ACC_ADD_SH     = 3'd3;
    localparam logic [2:0] ACC_LOAD_SPEED = 3'd4;

    // datapath register operations
    localparam logic [2:0] DP_NONE  = 3'd0;
    localparam logic [2:0] DP_TAKE  = 3'd1;
    localparam logic [2:0] DP_SPEED = 3'd2;
    localparam logic [2:0] DP_ERR   = 3'd3;
    localparam logic [2:0] DP_INTEG = 3'd4;
    localparam logic [2:0] DP_DRIVE = 3'd5;
    localparam logic [2:0] DP_OUT   = 3'd6;

    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_LAST = 4'd14;

    typedef struct packed {
        logic [1:0]      seq;
        logic [PC_W-1:0] target;
        logic [2:0]      mul;
        logic [2:0]      acc;
        logic [2:0]      dp;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } t_cond;

    typedef struct packed {
        logic [ENC_W-1:0] encoder_count;
        logic [REF_W-1:0] reference_speed;
        logic             clear_integral;
    } t_item;

    typedef struct packed {
        logic [GAIN_W-1:0] kp_gain;
        logic [GAIN_W-1:0] ki_dt_gain;
        logic [GAIN_W-1:0] kd_over_dt_gain;
        logic [GAIN_W-1:0] speed_scale;
        logic [GAIN_W-1:0] drive_to_duty_scale;
        logic [REF_W-1:0]  ref_limit;
        logic [DUTY_W-1:0] out_max;
    } t_cfg;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        logic [SPEED_W-1:0] measured_speed;
        logic               duty_clamped;
    } t_result;

    localparam t_ctrl CTRL_NOP = '{seq: SEQ_NEXT, target: '0, mul: MUL_NONE,
                                   acc: ACC_HOLD, dp: DP_NONE};

    // control store: one word per step; each product is registered in r_prod and
    // folded into the accumulator by the acc operation of the next step
    function automatic t_ctrl ucode_word(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w = CTRL_NOP;
        unique case (pc)
            4'd0: begin
                w.seq = SEQ_WAIT_IN;
                w.dp  = DP_TAKE;
            end
            4'd1: w.mul = MUL_DELTA;
            4'd2: w.acc = ACC_LOAD;
            4'd3: w.dp  = DP_SPEED;
            4'd4: begin
                w.dp  = DP_ERR;
                w.acc = ACC_LOAD_SPEED;
            end
            4'd5: begin
                w.dp  = DP_INTEG;
                w.mul = MUL_KP;
            end
            4'd6: begin
                w.mul = MUL_KD;
                w.acc = ACC_ADD;
            end
            4'd7: begin
                w.mul = MUL_KI_LO;
                w.acc = ACC_ADD;
            end
            4'd8: begin
                w.mul = MUL_KI_HI;
                w.acc = ACC_ADD;
            end
            4'd9:  w.acc = ACC_ADD_SH;
            4'd10: w.dp  = DP_DRIVE;
            4'd11: w.mul = MUL_DS_LO;
            4'd12: begin
                w.mul = MUL_DS_HI;
                w.acc = ACC_LOAD;
            end
            4'd13: w.acc = ACC_ADD_SH;
            4'd14: begin
                w.seq    = SEQ_WAIT_OUT;
                w.target = '0;
                w.dp     = DP_OUT;
            end
            default: w = CTRL_NOP;
        endcase
        return w;
    endfunction

endpackage

@@ hdl/esp_sequencer.sv @@
// step counter and control store of the speed controller
// depends on esp_pkg and assert_macros.svh
`include "assert_macros.svh"

module esp_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  esp_pkg::t_cond i_cond,
    output esp_pkg::t_ctrl o_ctrl
);

    logic [esp_pkg::PC_W-1:0] r_pc;
    logic [esp_pkg::PC_W-1:0] n_pc;
    esp_pkg::t_ctrl           ctrl;

    // control word fetch
    assign ctrl   = esp_pkg::ucode_word(r_pc);
    assign o_ctrl = ctrl;

    // next step, waits act as conditional jumps
    always_comb begin
        unique case (ctrl.seq)
            esp_pkg::SEQ_NEXT:     n_pc = r_pc + 1'b1;
            esp_pkg::SEQ_WAIT_IN:  n_pc = i_cond.in_valid ? r_pc + 1'b1 : r_pc;
            esp_pkg::SEQ_WAIT_OUT: n_pc = i_cond.out_free ? ctrl.target : r_pc;
            default:               n_pc = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else begin
            r_pc <= n_pc;
        end
    end

    `ESP_ASSERT_NXT(a_take_starts_run, i_clk, i_rst_n,
        ctrl.seq == esp_pkg::SEQ_WAIT_IN && i_cond.in_valid, r_pc == esp_pkg::PC_W'(1),
        "take did not start run")
    `ESP_ASSERT_NXT(a_out_wait_holds, i_clk, i_rst_n,
        r_pc == esp_pkg::PC_LAST && !i_cond.out_free, r_pc == esp_pkg::PC_LAST,
        "left final step with output blocked")

endmodule

@@ hdl/esp_datapath.sv @@
// datapath of the speed controller: shared multiplier, accumulator, pid state
// depends on esp_pkg; driven by the control word of esp_sequencer
module esp_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  esp_pkg::t_ctrl   i_ctrl,
    input  logic             i_take,
    input  esp_pkg::t_item   i_item,
    input  esp_pkg::t_cfg    i_cfg,
    output esp_pkg::t_result o_result
);

    logic [esp_pkg::COUNT_BITS-1:0]     r_prev_count;
    logic [esp_pkg::COUNT_BITS-1:0]     r_delta;
    logic [esp_pkg::REF_W-1:0]          r_ref;
    logic                               r_clr;
    logic [esp_pkg::SPEED_W-1:0]        r_speed;
    logic signed [esp_pkg::ERR_W-1:0]   r_err;
    logic signed [esp_pkg::ERR_W-1:0]   r_prev_err;
    logic signed [esp_pkg::DIFF_W-1:0]  r_diff;
    logic signed [esp_pkg::INTEG_W-1:0] r_integ;
    logic signed [esp_pkg::DRIVE_W-1:0] r_drive;
    logic signed [esp_pkg::PROD_W-1:0]  r_prod;
    logic signed [esp_pkg::ACC_W-1:0]   r_acc;

    logic [esp_pkg::COUNT_BITS-1:0]     count_cur;
    logic [esp_pkg::ACC_W-1:0]          spd_round;
    logic [esp_pkg::ACC_W-5:0]          spd_shift;
    logic [esp_pkg::SPEED_W-1:0]        spd_sat;
    logic [esp_pkg::REF_W-1:0]          ref_clip;
    logic signed [esp_pkg::ERR_W-1:0]   err_next;
    logic signed [esp_pkg::INTEG_W-1:0] integ_base;
    logic signed [esp_pkg::INTEG_W:0]   integ_sum;
    logic signed [esp_pkg::INTEG_W-1:0] integ_sat;
    logic signed [esp_pkg::DRIVE_W-1:0] drive_sat;
    logic signed [esp_pkg::MA_W-1:0]    mul_a;
    logic [esp_pkg::GAIN_W-1:0]         mul_b;
    logic signed [esp_pkg::ACC_W-1:0]   prod_ext;
    logic [esp_pkg::DFULL_W-1:0]        duty_full;

    assign count_cur = esp_pkg::COUNT_BITS'(i_item.encoder_count);

    // speed: round half up and drop four fraction bits, then saturate
    always_comb begin
        spd_round = r_acc + esp_pkg::ACC_W'(8);
        spd_shift = spd_round[esp_pkg::ACC_W-1:4];
        if (spd_shift > (esp_pkg::ACC_W-4)'(esp_pkg::SPEED_MAX)) begin
            spd_sat = esp_pkg::SPEED_MAX;
        end else begin
            spd_sat = spd_shift[esp_pkg::SPEED_W-1:0];
        end
    end

    // error against the clipped reference, both in q.8
    always_comb begin
        ref_clip = (r_ref > i_cfg.ref_limit) ? i_cfg.ref_limit : r_ref;
        err_next = $signed({{(esp_pkg::ERR_W-esp_pkg::REF_W-8){1'b0}}, ref_clip, 8'b0})
                 - $signed({{(esp_pkg::ERR_W-esp_pkg::SPEED_W){1'b0}}, r_speed});
    end

    // integral with optional clear and saturation at its width
    always_comb begin
        integ_base = r_clr ? '0 : r_integ;
        integ_sum  = (esp_pkg::INTEG_W+1)'(integ_base) + (esp_pkg::INTEG_W+1)'(r_err);
        if (integ_sum[esp_pkg::INTEG_W] != integ_sum[esp_pkg::INTEG_W-1]) begin
            integ_sat = integ_sum[esp_pkg::INTEG_W] ? esp_pkg::INTEG_MIN : esp_pkg::INTEG_MAX;
        end else begin
            integ_sat = integ_sum[esp_pkg::INTEG_W-1:0];
        end
    end

    // drive clamp to the symmetric cap
    always_comb begin
        if (r_acc > esp_pkg::DRIVE_CAP) begin
            drive_sat = esp_pkg::DRIVE_CAP[esp_pkg::DRIVE_W-1:0];
        end else if (r_acc < -esp_pkg::DRIVE_CAP) begin
            drive_sat = esp_pkg::DRIVE_W'(-esp_pkg::DRIVE_CAP);
        end else begin
            drive_sat = r_acc[esp_pkg::DRIVE_W-1:0];
        end
    end

    // multiplier operands; wide words go in as low and high chunks
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_ctrl.mul)
            esp_pkg::MUL_DELTA: begin
                mul_a = esp_pkg::MA_W'(r_delta);
                mul_b = i_cfg.speed_scale;
            end
            esp_pkg::MUL_KP: begin
                mul_a = esp_pkg::MA_W'(r_err);
                mul_b = i_cfg.kp_gain;
            end
            esp_pkg::MUL_KD: begin
                mul_a = esp_pkg::MA_W'(r_diff);
                mul_b = i_cfg.kd_over_dt_gain;
            end
            esp_pkg::MUL_KI_LO: begin
                mul_a = esp_pkg::MA_W'(r_integ[esp_pkg::LO_W-1:0]);
                mul_b = i_cfg.ki_dt_gain;
            end
            esp_pkg::MUL_KI_HI: begin
                mul_a = esp_pkg::MA_W'($signed(r_integ[esp_pkg::INTEG_W-1:esp_pkg::LO_W]));
                mul_b = i_cfg.ki_dt_gain;
            end
            esp_pkg::MUL_DS_LO: begin
                mul_a = esp_pkg::MA_W'(r_drive[esp_pkg::LO_W-1:0]);
                mul_b = i_cfg.drive_to_duty_scale;
            end
            esp_pkg::MUL_DS_HI: begin
                mul_a = esp_pkg::MA_W'($signed(r_drive[esp_pkg::DRIVE_W-1:esp_pkg::LO_W]));
                mul_b = i_cfg.drive_to_duty_scale;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_ext = esp_pkg::ACC_W'(r_prod);

    // product register and accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul != esp_pkg::MUL_NONE) begin
            r_prod <= mul_a * $signed({1'b0, mul_b});
        end
        case (i_ctrl.acc)
            esp_pkg::ACC_LOAD:       r_acc <= prod_ext;
            esp_pkg::ACC_ADD:        r_acc <= r_acc + prod_ext;
            esp_pkg::ACC_ADD_SH:     r_acc <= r_acc + (prod_ext <<< esp_pkg::LO_W);
            esp_pkg::ACC_LOAD_SPEED: r_acc <= $signed(esp_pkg::ACC_W'({r_speed, 8'b0}));
            default:                 r_acc <= r_acc;
        endcase
    end

    // working registers loaded step by step
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.dp)
            esp_pkg::DP_TAKE: begin
                if (i_take) begin
                    r_delta <= r_prev_count - count_cur;
                    r_ref   <= i_item.reference_speed;
                    r_clr   <= i_item.clear_integral;
                end
            end
            esp_pkg::DP_SPEED: r_speed <= spd_sat;
            esp_pkg::DP_ERR:   r_err   <= err_next;
            esp_pkg::DP_INTEG: r_diff  <= esp_pkg::DIFF_W'(r_err) - esp_pkg::DIFF_W'(r_prev_err);
            esp_pkg::DP_DRIVE: r_drive <= drive_sat;
            default: begin
            end
        endcase
    end

    // controller state kept across ticks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_count <= '0;
            r_integ      <= '0;
            r_prev_err   <= '0;
        end else begin
            if (i_ctrl.dp == esp_pkg::DP_TAKE && i_take) begin
                r_prev_count <= count_cur;
            end
            if (i_ctrl.dp == esp_pkg::DP_INTEG) begin
                r_integ    <= integ_sat;
                r_prev_err <= r_err;
            end
        end
    end

    // duty from the scaled drive, clamped to 0..out_max
    always_comb begin
        duty_full               = r_acc[esp_pkg::ACC_W-1:esp_pkg::LO_W];
        o_result.measured_speed = r_speed;
        if (r_acc[esp_pkg::ACC_W-1]) begin
            o_result.duty         = '0;
            o_result.duty_clamped = 1'b1;
        end else if (duty_full > esp_pkg::DFULL_W'(i_cfg.out_max)) begin
            o_result.duty         = i_cfg.out_max;
            o_result.duty_clamped = 1'b1;
        end else begin
            o_result.duty         = duty_full[esp_pkg::DUTY_W-1:0];
            o_result.duty_clamped = 1'b0;
        end
    end

endmodule

@@ hdl/encoder_speed_pid_motor_drive.sv @@
// top level of the encoder speed pid motor drive: config registers, stream ports
// depends on esp_pkg, esp_sequencer, esp_datapath and assert_macros.svh
`include "assert_macros.svh"

// One motor channel per control tick: each input transfer carries an encoder
// counter sample, a reference speed and an integral clear flag, and yields
// exactly one result with the duty, the measured speed and a clamp flag. A
// 15-step microprogram runs the tick on one shared 33x17 multiplier and a
// 64-bit accumulator; a new item is taken only after the previous tick has
// loaded its result, which waits while the output side is blocked; the
// output register lets the next item enter while the last result waits.
// Configuration registers are written through the cfg channel, which is
// always ready; write them only while no item is in flight.
module encoder_speed_pid_motor_drive (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [esp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [esp_pkg::GAIN_W-1:0]    i_cfg_data,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,  // encoder_count, reference_speed
    input  logic                          s_axis_tuser,  // clear_integral
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [47:0]                   m_axis_tdata,  // duty, measured_speed, zero pad
    output logic                          m_axis_tuser   // duty_clamped
);

    logic [esp_pkg::GAIN_W-1:0]  r_kp;
    logic [esp_pkg::GAIN_W-1:0]  r_ki;
    logic [esp_pkg::GAIN_W-1:0]  r_kd;
    logic [esp_pkg::GAIN_W-1:0]  r_spd_scale;
    logic [esp_pkg::GAIN_W-1:0]  r_dty_scale;
    logic [esp_pkg::REF_W-1:0]   r_ref_limit;
    logic [esp_pkg::DUTY_W-1:0]  r_out_max;

    logic                        r_out_valid;
    logic [esp_pkg::DUTY_W-1:0]  r_out_duty;
    logic [esp_pkg::SPEED_W-1:0] r_out_speed;
    logic                        r_out_clamped;

    esp_pkg::t_ctrl   ctrl;
    esp_pkg::t_cond   cond;
    esp_pkg::t_item   item;
    esp_pkg::t_cfg    cfg;
    esp_pkg::t_result result;
    logic             out_free;
    logic             take;
    logic             out_load;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp        <= 16'd90;
            r_ki        <= 16'd52;
            r_kd        <= 16'd0;
            r_spd_scale <= 16'd10792;
            r_dty_scale <= 16'd1969;
            r_ref_limit <= 8'd130;
            r_out_max   <= 16'd1000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                esp_pkg::CFG_KP:        r_kp        <= i_cfg_data;
                esp_pkg::CFG_KI:        r_ki        <= i_cfg_data;
                esp_pkg::CFG_KD:        r_kd        <= i_cfg_data;
                esp_pkg::CFG_SPD_SCALE: r_spd_scale <= i_cfg_data;
                esp_pkg::CFG_DTY_SCALE: r_dty_scale <= i_cfg_data;
                esp_pkg::CFG_REF_LIMIT: r_ref_limit <= i_cfg_data[esp_pkg::REF_W-1:0];
                esp_pkg::CFG_OUT_MAX:   r_out_max   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg = '{kp_gain: r_kp, ki_dt_gain: r_ki, kd_over_dt_gain: r_kd,
                   speed_scale: r_spd_scale, drive_to_duty_scale: r_dty_scale,
                   ref_limit: r_ref_limit, out_max: r_out_max};

    // input transfer taken only at the fetch step
    assign s_axis_tready = i_rst_n && (ctrl.seq == esp_pkg::SEQ_WAIT_IN);
    assign take          = s_axis_tvalid && s_axis_tready;
    assign item          = '{encoder_count: s_axis_tdata[15:0],
                             reference_speed: s_axis_tdata[23:16],
                             clear_integral: s_axis_tuser};

    // output register frees when its transfer completes
    assign out_free = !r_out_valid || m_axis_tready;
    assign out_load = (ctrl.dp == esp_pkg::DP_OUT) && out_free;
    assign cond     = '{in_valid: s_axis_tvalid, out_free: out_free};

    esp_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_ctrl  (ctrl)
    );

    esp_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_take   (take),
        .i_item   (item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_duty    <= result.duty;
            r_out_speed   <= result.measured_speed;
            r_out_clamped <= result.duty_clamped;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_speed, r_out_duty};
    assign m_axis_tuser  = r_out_clamped;

    `ESP_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, !s_axis_tready, "took a second item mid tick")
    `ESP_ASSERT_IMP(a_duty_in_range, i_clk, i_rst_n,
        r_out_valid, r_out_duty <= r_out_max, "duty above out_max")
    `ESP_ASSERT_IMP(a_clamp_at_bound, i_clk, i_rst_n,
        r_out_valid && r_out_clamped, r_out_duty == '0 || r_out_duty == r_out_max,
        "clamp flag without bound duty")

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the encoder speed pid motor drive: a directed table,
// then random control ticks over several gain settings; depends on esp_pkg and the rtl
module tb;

    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 150;
    localparam logic [esp_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    localparam longint SPEED_TOP = (longint'(1) <<< esp_pkg::SPEED_W) - 1;
    localparam longint INTEG_TOP = (longint'(1) <<< (esp_pkg::INTEG_W - 1)) - 1;
    localparam longint INTEG_BOT = -(longint'(1) <<< (esp_pkg::INTEG_W - 1));
    localparam longint DRIVE_TOP = (longint'(1) <<< (esp_pkg::DRIVE_W - 1)) - 1;

    typedef struct packed {
        esp_pkg::t_item   item;
        logic             known;
        esp_pkg::t_result want;
    } t_tick_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [esp_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [esp_pkg::GAIN_W-1:0]    i_cfg_data;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [23:0]                   s_axis_tdata;   // encoder_count, reference_speed
    logic                          s_axis_tuser;   // clear_integral
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [47:0]                   m_axis_tdata;   // duty, measured_speed, zero pad
    logic                          m_axis_tuser;   // duty_clamped

    // predictor state and its copy of the gain registers
    esp_pkg::t_cfg             gains;
    logic [esp_pkg::ENC_W-1:0] last_count;
    longint                    integ_sum;
    longint                    last_error;

    esp_pkg::t_result results_due [$];
    t_tick_row        bench_rows [$];
    esp_pkg::t_result got_result;
    esp_pkg::t_result due_result;
    int               bad_results   = 0;
    int               samples_taken = 0;
    int               idle_cycles   = 0;
    bit               quiet         = 1'b0;
    bit               hold_done     = 1'b0;

    encoder_speed_pid_motor_drive dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic esp_pkg::t_cfg mk_cfg(input logic [15:0] kp, input logic [15:0] ki,
                                             input logic [15:0] kd, input logic [15:0] ss,
                                             input logic [15:0] ds, input logic [7:0] rl,
                                             input logic [15:0] om);
        esp_pkg::t_cfg c;
        c.kp_gain             = kp;
        c.ki_dt_gain          = ki;
        c.kd_over_dt_gain     = kd;
        c.speed_scale         = ss;
        c.drive_to_duty_scale = ds;
        c.ref_limit           = rl;
        c.out_max             = om;
        return c;
    endfunction

    function automatic t_tick_row tick(input logic [15:0] enc, input logic [7:0] tgt,
                                       input logic clr);
        t_tick_row r;
        r.item.encoder_count   = enc;
        r.item.reference_speed = tgt;
        r.item.clear_integral  = clr;
        r.known                = 1'b0;
        r.want                 = '0;
        return r;
    endfunction

    function automatic t_tick_row tick_known(input logic [15:0] enc, input logic [7:0] tgt,
                                             input logic clr, input logic [15:0] duty,
                                             input logic [27:0] spd, input logic clamp);
        t_tick_row r;
        r                     = tick(enc, tgt, clr);
        r.known               = 1'b1;
        r.want.duty           = duty;
        r.want.measured_speed = spd;
        r.want.duty_clamped   = clamp;
        return r;
    endfunction

    // one control tick: speed from the down-count, pid, duty scaling and clamps
    function automatic esp_pkg::t_result drive_for_tick(input esp_pkg::t_item it);
        logic [esp_pkg::ENC_W-1:0] down;
        longint delta, spd, tgt, lim, err, isum, diff, pid, drv, prod, duty;
        longint kp, ki, kd, ss, ds, om;
        logic   clamp;
        esp_pkg::t_result r;
        kp = gains.kp_gain;
        ki = gains.ki_dt_gain;
        kd = gains.kd_over_dt_gain;
        ss = gains.speed_scale;
        ds = gains.drive_to_duty_scale;
        om = gains.out_max;
        lim = gains.ref_limit;

        down  = last_count - it.encoder_count;
        delta = down;
        spd   = (delta * ss + 8) >>> 4;
        if (spd > SPEED_TOP) spd = SPEED_TOP;
        last_count = it.encoder_count;

        tgt = it.reference_speed;
        if (tgt > lim) tgt = lim;
        err = (tgt <<< 8) - spd;

        if (it.clear_integral) integ_sum = 0;
        isum = integ_sum + err;
        if (isum > INTEG_TOP) isum = INTEG_TOP;
        if (isum < INTEG_BOT) isum = INTEG_BOT;
        integ_sum = isum;

        diff       = err - last_error;
        last_error = err;

        pid = kp * err + ki * isum + kd * diff;
        drv = (spd <<< 8) + pid;
        if (drv > DRIVE_TOP) drv = DRIVE_TOP;
        if (drv < -DRIVE_TOP) drv = -DRIVE_TOP;

        prod  = drv * ds;
        clamp = 1'b0;
        if (prod < 0) begin
            duty  = 0;
            clamp = 1'b1;
        end else begin
            duty = prod >>> 24;
            if (duty > om) begin
                duty  = om;
                clamp = 1'b1;
            end
        end

        r.duty           = duty[esp_pkg::DUTY_W-1:0];
        r.measured_speed = spd[esp_pkg::SPEED_W-1:0];
        r.duty_clamped   = clamp;
        return r;
    endfunction

    function automatic esp_pkg::t_cfg random_gains(input bit mild);
        if (mild)
            return mk_cfg(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 255)),
                          16'($urandom_range(0, 1023)), 16'($urandom_range(4000, 16000)),
                          16'($urandom_range(500, 4000)), 8'($urandom),
                          16'($urandom_range(500, 65535)));
        return mk_cfg(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 8'($urandom), 16'($urandom));
    endfunction

    // small down-counts as a turning motor gives in half the ticks, with stops, reversals and noise
    function automatic esp_pkg::t_item random_tick();
        esp_pkg::t_item it;
        int             pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            it.encoder_count = last_count - esp_pkg::ENC_W'($urandom_range(0, 400));
        else if (pick == 5)
            it.encoder_count = last_count;
        else if (pick == 6)
            it.encoder_count = last_count + esp_pkg::ENC_W'($urandom_range(1, 300));
        else
            it.encoder_count = esp_pkg::ENC_W'($urandom);
        pick = $urandom_range(0, 5);
        if (pick == 0)
            it.reference_speed = gains.ref_limit;
        else if (pick == 1)
            it.reference_speed = gains.ref_limit + 8'd1;
        else
            it.reference_speed = esp_pkg::REF_W'($urandom);
        it.clear_integral = ($urandom_range(0, 7) == 0);
        return it;
    endfunction

    // near-full down-counts with no clear, to drive the integral far negative
    function automatic esp_pkg::t_item climb_tick();
        esp_pkg::t_item it;
        it.encoder_count   = last_count + esp_pkg::ENC_W'($urandom_range(1, 48));
        it.reference_speed = esp_pkg::REF_W'($urandom);
        it.clear_integral  = 1'b0;
        return it;
    endfunction

    task automatic write_reg(input logic [esp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [esp_pkg::GAIN_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            esp_pkg::CFG_KP:        gains.kp_gain             = val;
            esp_pkg::CFG_KI:        gains.ki_dt_gain          = val;
            esp_pkg::CFG_KD:        gains.kd_over_dt_gain     = val;
            esp_pkg::CFG_SPD_SCALE: gains.speed_scale         = val;
            esp_pkg::CFG_DTY_SCALE: gains.drive_to_duty_scale = val;
            esp_pkg::CFG_REF_LIMIT: gains.ref_limit           = val[esp_pkg::REF_W-1:0];
            esp_pkg::CFG_OUT_MAX:   gains.out_max             = val;
            default: ;
        endcase
    endtask

    // all registers, junk in the unused upper byte of the limit, and a write to the spare index
    task automatic program_gains(input esp_pkg::t_cfg c);
        write_reg(CFG_SPARE, esp_pkg::GAIN_W'($urandom));
        write_reg(esp_pkg::CFG_KP, c.kp_gain);
        write_reg(esp_pkg::CFG_KI, c.ki_dt_gain);
        write_reg(esp_pkg::CFG_KD, c.kd_over_dt_gain);
        write_reg(esp_pkg::CFG_SPD_SCALE, c.speed_scale);
        write_reg(esp_pkg::CFG_DTY_SCALE, c.drive_to_duty_scale);
        write_reg(esp_pkg::CFG_REF_LIMIT, {8'($urandom), c.ref_limit});
        write_reg(esp_pkg::CFG_OUT_MAX, c.out_max);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_tick(input esp_pkg::t_item it, input logic known,
                             input esp_pkg::t_result want);
        esp_pkg::t_result pred;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tdata  <= {it.reference_speed, it.encoder_count};
        s_axis_tuser  <= it.clear_integral;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        samples_taken++;
        pred = drive_for_tick(it);
        results_due.push_back(known ? want : pred);
    endtask

    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input esp_pkg::t_cfg c, input int n, input bit climb);
        program_gains(c);
        repeat (n) send_tick(climb ? climb_tick() : random_tick(), 1'b0, '0);
        finish_phase();
    endtask

    // result side: random stall bursts, one long hold-off to back the block up
    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!hold_done && samples_taken >= HOLD_AFTER) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
                m_axis_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // compare each result transfer with the oldest pending prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_result.duty           = m_axis_tdata[esp_pkg::DUTY_W-1:0];
            got_result.measured_speed = m_axis_tdata[esp_pkg::DUTY_W +: esp_pkg::SPEED_W];
            got_result.duty_clamped   = m_axis_tuser;
            if (results_due.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("%0t: unexpected result duty=%0d speed=%0d clamped=%0b",
                             $realtime, got_result.duty, got_result.measured_speed,
                             got_result.duty_clamped);
            end else begin
                due_result = results_due.pop_front();
                if (got_result !== due_result) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display({"%0t: mismatch duty exp %0d got %0d, speed exp %0d got %0d,",
                                  " clamped exp %0b got %0b"}, $realtime,
                                 due_result.duty, got_result.duty,
                                 due_result.measured_speed, got_result.measured_speed,
                                 due_result.duty_clamped, got_result.duty_clamped);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        gains         = mk_cfg(16'd90, 16'd52, 16'd0, 16'd10792, 16'd1969, 8'd130, 16'd1000);
        last_count    = '0;
        integ_sum     = 0;
        last_error    = 0;

        // reset gains, state starting at zero
        bench_rows = '{
            // nothing moving, nothing asked
            tick_known(16'h0000, 8'd0, 1'b0, 16'd0, 28'd0, 1'b0),
            // one count up wraps to a full down-count: duty pinned at out_max
            tick_known(16'h0001, 8'd0, 1'b1, 16'd1000, 28'd44203358, 1'b1),
            // stopped with a negative integral: drive below zero
            tick_known(16'h0001, 8'd0, 1'b0, 16'd0, 28'd0, 1'b1),
            tick(16'h0001, 8'd255, 1'b1),
            tick(16'h0000, 8'd130, 1'b0),
            tick(16'hFFFF, 8'd131, 1'b0),
            tick(16'hFFFF, 8'd255, 1'b0),
            tick(16'h0000, 8'd0, 1'b1),
            tick(16'h8000, 8'd129, 1'b0),
            tick(16'h7FF0, 8'd1, 1'b1),
            tick(16'h7FE0, 8'h80, 1'b0),
            tick(16'h5555, 8'hAA, 1'b1),
            tick(16'hAAAA, 8'h55, 1'b0),
            tick(16'hAAA0, 8'd100, 1'b0)
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (bench_rows[k])
            send_tick(bench_rows[k].item, bench_rows[k].known, bench_rows[k].want);
        finish_phase();

        run_phase(random_gains(1'b0), 200, 1'b0);
        run_phase(mk_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF),
                  120, 1'b0);
        run_phase(mk_cfg(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'h0, 16'h0), 60, 1'b0);
        run_phase(random_gains(1'b1), 200, 1'b0);
        // long run of large negative errors, integral grows deep below zero
        run_phase(mk_cfg(16'($urandom_range(0, 1023)), 16'hFFFF, 16'($urandom),
                         16'hFFFF, 16'($urandom), 8'hFF, 16'hFFFF), 260, 1'b1);
        quiet = 1'b1;
        run_phase(mk_cfg(16'd90, 16'd52, 16'd200, 16'd10792, 16'd1969, 8'd130, 16'd1000),
                  200, 1'b0);

        if (bad_results == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
